@@ sv/cpio_pkg.sv @@
package cpio_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned NSIZE_W  = 18;
  localparam int unsigned FSIZE_W  = 32;

  localparam logic [CNT_W-1:0]   HDR_BYTES         = 32'd76;
  localparam logic [CNT_W-1:0]   HDR_LAST          = 32'd75;
  localparam logic [CNT_W-1:0]   NSIZE_AT          = 32'd59;
  localparam logic [CNT_W-1:0]   FSIZE_AT          = 32'd65;
  localparam logic [CNT_W-1:0]   TRAILER_CMP_LEN   = 32'd10;
  localparam logic [NSIZE_W-1:0] TRAILER_NAME_SIZE = 18'd11;
  localparam logic [BYTE_W-1:0]  ASCII_ZERO        = 8'h30;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [KIND_W-1:0]  kind;
    logic [CNT_W-1:0]   offset;
    logic [NSIZE_W-1:0] name_length;
    logic [FSIZE_W-1:0] data_length;
    logic               last;
    logic               archive_end;
  } result_t;

  // Name of the end-of-archive entry, one character per position.
  function automatic logic [BYTE_W-1:0] trailer_char(input logic [3:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      4'd0:    c = 8'h54; // T
      4'd1:    c = 8'h52; // R
      4'd2:    c = 8'h41; // A
      4'd3:    c = 8'h49; // I
      4'd4:    c = 8'h4C; // L
      4'd5:    c = 8'h45; // E
      4'd6:    c = 8'h52; // R
      default: c = 8'h21; // !
    endcase
    return c;
  endfunction

endpackage

@@ sv/cpio_odc_stream_deframer.sv @@
// Channel  Ports                                   Direction  Request
// input    in_valid in_stall in_byte               sink       one archive byte
// result   out_valid out_stall out_byte out_*      source     one labelled byte
//
// One byte is accepted per cycle while in_stall is low; its result is registered.
// The header/name/data sequencer and both octal accumulators update in the
// accepting cycle, so the loop through them sets the one-byte-per-cycle rate.
// A two-entry output (result register plus skid register) lets one more
// request in while out_stall holds; in_stall rises only when both are full.
// rst_n is synchronous, active low; it returns the parser to the header phase.
module cpio_odc_stream_deframer
  import cpio_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   in_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BYTE_W-1:0]   out_byte,
  output logic [KIND_W-1:0]   out_part_kind,
  output logic [CNT_W-1:0]    out_part_offset,
  output logic [NSIZE_W-1:0]  out_name_length,
  output logic [FSIZE_W-1:0]  out_data_length,
  output logic                out_part_last,
  output logic                out_archive_end
);

  typedef enum logic [KIND_W-1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_DATA   = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [CNT_W-1:0]     byte_counter_r, byte_counter_nxt;
  logic [NSIZE_W-1:0]   nsize_r, nsize_nxt;
  logic [FSIZE_W-1:0]   fsize_r, fsize_nxt;
  logic                 tmatch_r, tmatch_nxt;

  logic                 out_valid_r, skid_valid_r;
  result_t              out_r, skid_r, res_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic [CNT_W-1:0]     off_inc;
  logic [FSIZE_W-1:0]   digit;
  logic [NSIZE_W-1:0]   nsize_base;
  logic [FSIZE_W-1:0]   fsize_base;
  logic                 last;
  logic                 arch_end;
  logic                 name_mismatch;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;
  assign off_inc  = byte_counter_r + 32'd1;
  assign digit    = {{(FSIZE_W-BYTE_W){1'b0}}, in_byte} - {{(FSIZE_W-BYTE_W){1'b0}}, ASCII_ZERO};

  always_comb begin
    nsize_base       = (byte_counter_r == NSIZE_AT) ? '0 : {nsize_r[NSIZE_W-4:0], 3'b000};
    fsize_base       = (byte_counter_r == FSIZE_AT) ? '0 : {fsize_r[FSIZE_W-4:0], 3'b000};
    name_mismatch    = (byte_counter_r < TRAILER_CMP_LEN) &&
                       (in_byte != trailer_char(byte_counter_r[3:0]));
    phase_nxt        = phase_r;
    byte_counter_nxt = off_inc;
    nsize_nxt        = nsize_r;
    fsize_nxt        = fsize_r;
    tmatch_nxt       = tmatch_r;
    last             = 1'b0;
    arch_end         = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        if (byte_counter_r >= NSIZE_AT && byte_counter_r < FSIZE_AT) begin
          nsize_nxt = nsize_base + digit[NSIZE_W-1:0];
        end else if (byte_counter_r >= FSIZE_AT && byte_counter_r < HDR_BYTES) begin
          fsize_nxt = fsize_base + digit;
        end
        if (byte_counter_r == HDR_LAST) begin
          last             = 1'b1;
          tmatch_nxt       = 1'b1;
          byte_counter_nxt = '0;
          if (nsize_nxt != '0) begin
            phase_nxt = PH_NAME;
          end else if (fsize_nxt != '0) begin
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end
      end
      PH_NAME: begin
        tmatch_nxt = tmatch_r && !name_mismatch;
        if (off_inc == {{(CNT_W-NSIZE_W){1'b0}}, nsize_r}) begin
          last             = 1'b1;
          byte_counter_nxt = '0;
          if (nsize_r == TRAILER_NAME_SIZE && tmatch_nxt) begin
            arch_end  = 1'b1;
            phase_nxt = PH_IGNORE;
          end else if (fsize_r != '0) begin
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end
      end
      PH_DATA: begin
        if (off_inc == fsize_r) begin
          last             = 1'b1;
          byte_counter_nxt = '0;
          phase_nxt        = PH_HEADER;
        end
      end
      PH_IGNORE: begin
        phase_nxt = PH_IGNORE;
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    res_nxt.data        = in_byte;
    res_nxt.kind        = phase_r;
    res_nxt.offset      = byte_counter_r;
    res_nxt.name_length = nsize_nxt;
    res_nxt.data_length = fsize_nxt;
    res_nxt.last        = last;
    res_nxt.archive_end = arch_end;
  end

  // Parser state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      byte_counter_r <= '0;
      nsize_r        <= '0;
      fsize_r        <= '0;
      tmatch_r       <= 1'b1;
    end else if (in_acc) begin
      phase_r        <= phase_nxt;
      byte_counter_r <= byte_counter_nxt;
      nsize_r        <= nsize_nxt;
      fsize_r        <= fsize_nxt;
      tmatch_r       <= tmatch_nxt;
    end
  end

  // Result register with skid: drain skid first, else take the new result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc) begin
        out_r <= res_nxt;
      end
    end else if (in_acc) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_r.data;
  assign out_part_kind   = out_r.kind;
  assign out_part_offset = out_r.offset;
  assign out_name_length = out_r.name_length;
  assign out_data_length = out_r.data_length;
  assign out_part_last   = out_r.last;
  assign out_archive_end = out_r.archive_end;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the result register is empty");

  a_end_on_name_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.archive_end) |-> (out_r.last && out_r.kind == PH_NAME))
    else $error("archive end flagged off the last name byte");

  a_ignore_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IGNORE) |=> (phase_r == PH_IGNORE))
    else $error("parser left the ignore phase");

  a_header_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (byte_counter_r < HDR_BYTES))
    else $error("header offset ran past the header");

endmodule

@@ dv/deframer_check_pkg.sv @@
package deframer_check_pkg;
  import cpio_pkg::*;

  typedef enum logic [KIND_W-1:0] {
    PART_HEADER  = 2'd0,
    PART_NAME    = 2'd1,
    PART_DATA    = 2'd2,
    PART_IGNORED = 2'd3
  } part_e;

  localparam logic [79:0] TRAILER_TAG = "TRAILER!!!";

  class deframe_scoreboard;
    part_e              phase;
    logic [CNT_W-1:0]   pos;
    logic [NSIZE_W-1:0] name_acc;
    logic [FSIZE_W-1:0] file_acc;
    bit                 tag_ok;
    result_t            labels_due[$];
    int unsigned        mismatches;
    int unsigned        labelled;
    int unsigned        parts_closed;
    int unsigned        ends_seen;

    function new();
      phase        = PART_HEADER;
      pos          = '0;
      name_acc     = '0;
      file_acc     = '0;
      tag_ok       = 1'b1;
      mismatches   = 0;
      labelled     = 0;
      parts_closed = 0;
      ends_seen    = 0;
    endfunction

    // Skip the data part when the file size is zero.
    function void leave_part();
      pos   = '0;
      phase = (file_acc != '0) ? PART_DATA : PART_HEADER;
    endfunction

    function void label_byte(input logic [BYTE_W-1:0] b);
      result_t     r;
      logic [31:0] digit;
      logic [31:0] base;
      int unsigned idx;
      digit = {24'd0, b} - {24'd0, ASCII_ZERO};
      r        = '0;
      r.data   = b;
      r.kind   = phase;
      r.offset = pos;
      case (phase)
        PART_HEADER: begin
          if (pos >= NSIZE_AT && pos < FSIZE_AT) begin
            base     = (pos == NSIZE_AT) ? 32'd0 : ({14'd0, name_acc} << 3);
            name_acc = NSIZE_W'(base + digit);
          end else if (pos >= FSIZE_AT && pos < HDR_BYTES) begin
            base     = (pos == FSIZE_AT) ? 32'd0 : (file_acc << 3);
            file_acc = base + digit;
          end
          if (pos == HDR_LAST) begin
            r.last = 1'b1;
            tag_ok = 1'b1;
            if (name_acc != '0) begin
              pos   = '0;
              phase = PART_NAME;
            end else begin
              leave_part();
            end
          end else begin
            pos = pos + 32'd1;
          end
        end
        PART_NAME: begin
          if (pos < TRAILER_CMP_LEN) begin
            idx = pos;
            if (b != TRAILER_TAG[8*(9-idx) +: 8]) tag_ok = 1'b0;
          end
          if (pos + 32'd1 == {14'd0, name_acc}) begin
            r.last = 1'b1;
            if (name_acc == TRAILER_NAME_SIZE && tag_ok) begin
              r.archive_end = 1'b1;
              pos           = '0;
              phase         = PART_IGNORED;
            end else begin
              leave_part();
            end
          end else begin
            pos = pos + 32'd1;
          end
        end
        PART_DATA: begin
          if (pos + 32'd1 == file_acc) begin
            r.last = 1'b1;
            pos    = '0;
            phase  = PART_HEADER;
          end else begin
            pos = pos + 32'd1;
          end
        end
        default: pos = pos + 32'd1;
      endcase
      r.name_length = name_acc;
      r.data_length = file_acc;
      labels_due.push_back(r);
    endfunction

    function void match_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_labelled(input result_t got);
      result_t want;
      if (labels_due.size() == 0) begin
        mismatches++;
        $display("%0t: result byte %0h with no request pending, expected none",
                 $time, got.data);
        return;
      end
      want = labels_due.pop_front();
      labelled++;
      if (got.last === 1'b1) parts_closed++;
      if (got.archive_end === 1'b1) ends_seen++;
      match_field("out_byte", 32'(want.data), 32'(got.data));
      match_field("out_part_kind", 32'(want.kind), 32'(got.kind));
      match_field("out_part_offset", want.offset, got.offset);
      match_field("out_name_length", 32'(want.name_length), 32'(got.name_length));
      match_field("out_data_length", want.data_length, got.data_length);
      match_field("out_part_last", 32'(want.last), 32'(got.last));
      match_field("out_archive_end", 32'(want.archive_end), 32'(got.archive_end));
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
module tb_top;
  import cpio_pkg::*;
  import deframer_check_pkg::*;

  localparam int unsigned IDLE_LIMIT      = 5000;
  localparam int unsigned STREAM_BYTES    = 2000;
  localparam int unsigned HOLD_OFF_AT     = 600;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned TAIL_BYTES      = 40;
  localparam logic [47:0] MAGIC_ODC       = "070707";

  typedef enum {SIZE_PLAIN, SIZE_JUNK, SIZE_WRAP} size_form_e;
  typedef enum {NAME_RANDOM, NAME_TRAILER, NAME_TRAILER_BROKEN} name_form_e;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [BYTE_W-1:0]  in_byte   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic [KIND_W-1:0]  out_part_kind;
  logic [CNT_W-1:0]   out_part_offset;
  logic [NSIZE_W-1:0] out_name_length;
  logic [FSIZE_W-1:0] out_data_length;
  logic               out_part_last;
  logic               out_archive_end;

  deframe_scoreboard sb;
  bit                tx_burst;
  bit                rx_burst;
  int unsigned       bytes_sent;
  int unsigned       entries_sent;

  always #5 clk = ~clk;

  cpio_odc_stream_deframer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_part_kind   (out_part_kind),
    .out_part_offset (out_part_offset),
    .out_name_length (out_name_length),
    .out_data_length (out_data_length),
    .out_part_last   (out_part_last),
    .out_archive_end (out_archive_end)
  );

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.label_byte(b);
    bytes_sent++;
  endtask

  // The first two size digits cancel to zero, so the size stays small while
  // non-digit bytes reach the accumulators; '/' then '8' shows all ones first.
  function automatic logic [15:0] cancel_pair(input size_form_e sf);
    int lead;
    lead = (sf == SIZE_WRAP) ? 47 : int'($urandom_range(23, 54));
    return {8'(lead), 8'(48 - 8 * (lead - 48))};
  endfunction

  task automatic send_entry(input int unsigned nsz, input int unsigned fsz,
                            input size_form_e nf, input size_form_e ff,
                            input name_form_e form);
    logic [BYTE_W-1:0] hdr [76];
    logic [BYTE_W-1:0] c;
    int unsigned       bad_pos;
    for (int i = 0; i < 76; i++) hdr[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0)
      for (int i = 0; i < 6; i++) hdr[i] = MAGIC_ODC[8*(5-i) +: 8];
    for (int i = 0; i < 6; i++)
      hdr[NSIZE_AT+i] = ASCII_ZERO + 8'((nsz >> (3 * (5 - i))) & 7);
    for (int i = 0; i < 11; i++)
      hdr[FSIZE_AT+i] = ASCII_ZERO + 8'((fsz >> (3 * (10 - i))) & 7);
    if (nf != SIZE_PLAIN) {hdr[NSIZE_AT], hdr[NSIZE_AT+1]} = cancel_pair(nf);
    if (ff != SIZE_PLAIN) {hdr[FSIZE_AT], hdr[FSIZE_AT+1]} = cancel_pair(ff);
    for (int i = 0; i < 76; i++) send_byte(hdr[i]);

    bad_pos = $urandom_range(0, 9);
    for (int i = 0; i < nsz; i++) begin
      c = 8'($urandom_range(0, 255));
      if (form != NAME_RANDOM && i < 10) begin
        c = TRAILER_TAG[8*(9-i) +: 8];
        if (form == NAME_TRAILER_BROKEN && i == bad_pos) c ^= 8'($urandom_range(1, 255));
      end
      send_byte(c);
    end
    // A real trailer enters the ignored phase; its file size has no data.
    if (!(form == NAME_TRAILER && nsz == 11))
      for (int i = 0; i < fsz; i++) send_byte(8'($urandom_range(0, 255)));
    entries_sent++;
  endtask

  initial begin : stimulus
    int unsigned nsz;
    int unsigned fsz;
    int unsigned pick;
    size_form_e  nf;
    size_form_e  ff;
    name_form_e  form;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_entry(1, 1, SIZE_WRAP, SIZE_WRAP, NAME_RANDOM);
    send_entry(0, 0, SIZE_PLAIN, SIZE_PLAIN, NAME_RANDOM);
    send_entry(0, 5, SIZE_JUNK, SIZE_PLAIN, NAME_RANDOM);
    send_entry(3, 0, SIZE_PLAIN, SIZE_JUNK, NAME_RANDOM);
    send_entry(11, 2, SIZE_PLAIN, SIZE_PLAIN, NAME_TRAILER_BROKEN);
    send_entry(10, 1, SIZE_PLAIN, SIZE_PLAIN, NAME_TRAILER);
    send_entry(12, 0, SIZE_PLAIN, SIZE_PLAIN, NAME_TRAILER);

    while (bytes_sent < STREAM_BYTES) begin
      tx_burst = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 15);
      nsz  = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(21, 300) : $urandom_range(1, 20);
      pick = $urandom_range(0, 15);
      fsz  = (pick < 2) ? 0 : (pick == 2) ? $urandom_range(41, 400) : $urandom_range(1, 40);
      pick = $urandom_range(0, 9);
      nf   = (pick == 0) ? SIZE_WRAP : (pick < 3) ? SIZE_JUNK : SIZE_PLAIN;
      pick = $urandom_range(0, 9);
      ff   = (pick == 0) ? SIZE_WRAP : (pick < 3) ? SIZE_JUNK : SIZE_PLAIN;
      pick = $urandom_range(0, 9);
      form = NAME_RANDOM;
      if (pick == 0) begin
        form = NAME_TRAILER_BROKEN;
        nsz  = 11;
      end else if (pick == 1) begin
        form = NAME_TRAILER;
        nsz  = $urandom_range(0, 1) ? 10 : 12;
      end
      send_entry(nsz, fsz, nf, ff, form);
    end

    tx_burst = 1'b0;
    send_entry(11, $urandom_range(0, 9), SIZE_JUNK, SIZE_PLAIN, NAME_TRAILER);
    for (int i = 0; i < TAIL_BYTES; i++) send_byte(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    while (sb.labels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("run covered %0d entries (trailer last), %0d bytes labelled, %0d part ends",
             entries_sent, sb.labelled, sb.parts_closed);
    $display("end of archive flagged %0d time(s), %0d mismatch(es)",
             sb.ends_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.labels_due.size() == 0) begin
      $display("** cpio_odc_stream_deframer: PASSED **");
    end else begin
      $display("** cpio_odc_stream_deframer: FAILED **");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned hold;
    bit          held;
    result_t     got;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.data        = out_byte;
        got.kind        = out_part_kind;
        got.offset      = out_part_offset;
        got.name_length = out_name_length;
        got.data_length = out_data_length;
        got.last        = out_part_last;
        got.archive_end = out_archive_end;
        sb.check_labelled(got);
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
        // Hold off once for a long stretch so the block fills and stalls its input.
        if (!held && sb.labelled >= HOLD_OFF_AT) begin
          held = 1'b1;
          hold = HOLD_OFF_CYCLES;
        end else begin
          hold = rx_burst ? 0 : $urandom_range(0, 12);
        end
        if (hold != 0) out_stall <= 1'b1;
      end else if (hold != 0) begin
        hold--;
        if (hold == 0) out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
    $display("** cpio_odc_stream_deframer: FAILED **");
    $finish;
  end

endmodule

@@ cpio_odc_stream_deframer.f @@
sv/cpio_pkg.sv
sv/cpio_odc_stream_deframer.sv
dv/deframer_check_pkg.sv
dv/tb_top.sv
